// ----- sv/cptr_pkg.sv -----
// Shared types, constants and helpers for the point-to-rectangle clamp.
`timescale 1ns / 1ps

package cptr_pkg;

    localparam int CW        = 32;          // coordinate width, Q16.16
    localparam int PW        = 2 * CW + 2;  // wide product / cross term width
    localparam int NW        = 2 * CW;      // numerator width for the hit divide
    localparam int DIV_STEPS = CW;          // quotient bits, one per stage
    localparam int AW        = 4;           // APB address width

    typedef enum logic [1:0] {
        REG_MIN_X = 2'd0,
        REG_MIN_Y = 2'd1,
        REG_MAX_X = 2'd2,
        REG_MAX_Y = 2'd3
    } reg_idx_t;

    // sideband that rides along the divider
    typedef struct packed {
        logic                 hit;
        logic                 swap;   // hit on top or bottom edge
        logic signed [CW-1:0] c;
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
    } side_t;

    // num/den lies in [0,1] with den nonzero
    function automatic logic in_unit(input logic signed [PW-1:0] num,
                                     input logic signed [PW-1:0] den);
        logic r;
        if (den == '0)
            r = 1'b0;
        else if (!den[PW-1])
            r = !num[PW-1] && (num <= den);
        else
            r = ((num == '0) || num[PW-1]) && (num >= den);
        return r;
    endfunction

endpackage

// ----- sv/cptr_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with sideband.
`timescale 1ns / 1ps

module cptr_div
    import cptr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [NW-1:0] in_n,
    input  logic signed [CW-1:0] in_d,
    input  side_t                in_side,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [CW-1:0] out_q,
    output side_t                out_side
);

    logic          v_reg    [0:DIV_STEPS];
    logic [CW-1:0] rem_reg  [0:DIV_STEPS];
    logic [CW-1:0] wk_reg   [0:DIV_STEPS];
    logic [CW-1:0] dv_reg   [0:DIV_STEPS];
    logic          neg_reg  [0:DIV_STEPS];
    side_t         side_reg [0:DIV_STEPS];
    logic          adv      [0:DIV_STEPS];

    logic [NW-1:0] n_mag;
    logic [CW-1:0] d_mag;
    logic [CW-1:0] q_mag;

    always_comb
    begin
        n_mag = in_n[NW-1] ? NW'(-in_n) : NW'(in_n);
        d_mag = in_d[CW-1] ? CW'(-in_d) : CW'(in_d);
    end

    always_comb
    begin
        adv[DIV_STEPS] = !v_reg[DIV_STEPS] || out_ready;
        for (int k = DIV_STEPS - 1; k >= 0; k--)
            adv[k] = !v_reg[k] || adv[k+1];
    end

    assign in_ready = adv[0];

    // prep stage: magnitudes and result sign
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (adv[0])
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0] && in_valid)
        begin
            rem_reg[0]  <= n_mag[NW-1:CW];
            wk_reg[0]   <= n_mag[CW-1:0];
            dv_reg[0]   <= d_mag;
            neg_reg[0]  <= in_n[NW-1] != in_d[CW-1];
            side_reg[0] <= in_side;
        end
    end

    genvar g;
    generate
        for (g = 1; g <= DIV_STEPS; g++)
        begin : g_step
            logic [CW:0]   trial;
            logic          ge;
            logic [CW-1:0] rem_next;

            always_comb
            begin
                trial    = {rem_reg[g-1], wk_reg[g-1][CW-1]};
                ge       = trial >= {1'b0, dv_reg[g-1]};
                rem_next = ge ? CW'(trial - {1'b0, dv_reg[g-1]}) : trial[CW-1:0];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[g] <= 1'b0;
                else if (adv[g])
                    v_reg[g] <= v_reg[g-1];
            end

            always_ff @(posedge clk)
            begin
                if (adv[g] && v_reg[g-1])
                begin
                    rem_reg[g]  <= rem_next;
                    wk_reg[g]   <= {wk_reg[g-1][CW-2:0], ge};
                    dv_reg[g]   <= dv_reg[g-1];
                    neg_reg[g]  <= neg_reg[g-1];
                    side_reg[g] <= side_reg[g-1];
                end
            end
        end
    endgenerate

    assign q_mag     = wk_reg[DIV_STEPS];
    assign out_valid = v_reg[DIV_STEPS];
    assign out_q     = neg_reg[DIV_STEPS] ? CW'(-q_mag) : CW'(q_mag);
    assign out_side  = side_reg[DIV_STEPS];

endmodule

// ----- sv/clamp_point_toward_origin_to_rect.sv -----
// Top level: clamps the origin-to-point segment onto the configured rectangle border.
// A word passes the point, product, cross-term and edge-pick stages, the divider and the output register.
// Throughput: one word per cycle; stall back-pressure travels stage by stage,
// so bubbles collapse and a word is taken while the output word waits.
// The 32-stage quotient pipeline sets the latency.
// Reset: asynchronous active low; clears valid bits, borders go to -1.0 / +1.0.
`timescale 1ns / 1ps

module clamp_point_toward_origin_to_rect
    import cptr_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    // APB configuration
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [AW-1:0]   paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready,
    // input stream
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [2*CW-1:0] s_tdata,    // point_x [31:0], point_y [63:32]
    // output stream
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [2*CW-1:0] m_tdata,    // out_x [31:0], out_y [63:32]
    output logic [0:0]      m_tuser     // was_clamped [0]
);

    // ---------------- configuration ----------------
    logic signed [CW-1:0] min_x_reg, min_y_reg, max_x_reg, max_y_reg;
    logic signed [CW:0]   dx_reg, dy_reg;
    reg_idx_t             widx;

    assign pready = 1'b1;
    assign widx   = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg <= -CW'(65536);
            min_y_reg <= -CW'(65536);
            max_x_reg <= CW'(65536);
            max_y_reg <= CW'(65536);
        end
        else if (psel && penable && pwrite)
        begin
            case (widx)
                REG_MIN_X: min_x_reg <= pwdata[CW-1:0];
                REG_MIN_Y: min_y_reg <= pwdata[CW-1:0];
                REG_MAX_X: max_x_reg <= pwdata[CW-1:0];
                REG_MAX_Y: max_y_reg <= pwdata[CW-1:0];
                default:   min_x_reg <= min_x_reg;
            endcase
        end
    end

    always_comb
    begin
        case (widx)
            REG_MIN_X: prdata = min_x_reg;
            REG_MIN_Y: prdata = min_y_reg;
            REG_MAX_X: prdata = max_x_reg;
            REG_MAX_Y: prdata = max_y_reg;
            default:   prdata = '0;
        endcase
    end

    // edge spans, settled before any word reaches the product stage
    always_ff @(posedge clk)
    begin
        dx_reg <= (CW+1)'(max_x_reg) - (CW+1)'(min_x_reg);
        dy_reg <= (CW+1)'(max_y_reg) - (CW+1)'(min_y_reg);
    end

    // ---------------- pipeline ----------------
    logic adv1, adv2, adv3, adv4, div_ready;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    assign adv4     = !v4_reg || div_ready;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign s_tready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= s_tvalid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
    end

    // stage 1: capture point
    logic signed [CW-1:0] px1_reg, py1_reg;

    always_ff @(posedge clk)
    begin
        if (adv1 && s_tvalid)
        begin
            px1_reg <= s_tdata[CW-1:0];
            py1_reg <= s_tdata[2*CW-1:CW];
        end
    end

    // stage 2: products
    logic signed [CW-1:0]   px2_reg, py2_reg;
    logic signed [2*CW:0]   pxdy_next, pydx_next, pxdy_reg, pydx_reg;
    logic signed [2*CW-1:0] pyminx_next, pymaxx_next, pxminy_next, pxmaxy_next;
    logic signed [2*CW-1:0] pyminx_reg, pymaxx_reg, pxminy_reg, pxmaxy_reg;

    always_comb
    begin
        pxdy_next   = px1_reg * dy_reg;
        pydx_next   = py1_reg * dx_reg;
        pyminx_next = py1_reg * min_x_reg;
        pymaxx_next = py1_reg * max_x_reg;
        pxminy_next = px1_reg * min_y_reg;
        pxmaxy_next = px1_reg * max_y_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && v1_reg)
        begin
            px2_reg    <= px1_reg;
            py2_reg    <= py1_reg;
            pxdy_reg   <= pxdy_next;
            pydx_reg   <= pydx_next;
            pyminx_reg <= pyminx_next;
            pymaxx_reg <= pymaxx_next;
            pxminy_reg <= pxminy_next;
            pxmaxy_reg <= pxmaxy_next;
        end
    end

    // stage 3: cross terms and t-range tests; edge order left, right, top, bottom
    logic signed [CW-1:0]   px3_reg, py3_reg;
    logic signed [PW-1:0]   num3_next [0:3];
    logic signed [PW-1:0]   num3_reg  [0:3];
    logic signed [PW-1:0]   denx3_reg, deny3_reg;
    logic [3:0]             tok3_next, tok3_reg;
    logic signed [2*CW-1:0] n3_reg [0:3];

    always_comb
    begin
        num3_next[0] = PW'(pyminx_reg) - PW'(pxminy_reg);
        num3_next[1] = PW'(pymaxx_reg) - PW'(pxminy_reg);
        num3_next[2] = PW'(pxmaxy_reg) - PW'(pyminx_reg);
        num3_next[3] = PW'(pxminy_reg) - PW'(pyminx_reg);
        tok3_next[0] = in_unit(PW'(min_x_reg), PW'(px2_reg));
        tok3_next[1] = in_unit(PW'(max_x_reg), PW'(px2_reg));
        tok3_next[2] = in_unit(PW'(max_y_reg), PW'(py2_reg));
        tok3_next[3] = in_unit(PW'(min_y_reg), PW'(py2_reg));
    end

    always_ff @(posedge clk)
    begin
        if (adv3 && v2_reg)
        begin
            px3_reg   <= px2_reg;
            py3_reg   <= py2_reg;
            num3_reg  <= num3_next;
            denx3_reg <= PW'(pxdy_reg);
            deny3_reg <= PW'(pydx_reg);
            tok3_reg  <= tok3_next;
            n3_reg[0] <= pyminx_reg;
            n3_reg[1] <= pymaxx_reg;
            n3_reg[2] <= pxmaxy_reg;
            n3_reg[3] <= pxminy_reg;
        end
    end

    // stage 4: pick the first edge hit
    logic [3:0]             hit4;
    logic signed [2*CW-1:0] n4_next, n4_reg;
    logic signed [CW-1:0]   a4_next, a4_reg;
    side_t                  side4_next, side4_reg;

    always_comb
    begin
        hit4[0] = tok3_reg[0] && in_unit(num3_reg[0], denx3_reg);
        hit4[1] = tok3_reg[1] && in_unit(num3_reg[1], denx3_reg);
        hit4[2] = tok3_reg[2] && in_unit(num3_reg[2], deny3_reg);
        hit4[3] = tok3_reg[3] && in_unit(num3_reg[3], deny3_reg);

        side4_next.hit  = |hit4;
        side4_next.swap = 1'b0;
        side4_next.c    = min_x_reg;
        side4_next.px   = px3_reg;
        side4_next.py   = py3_reg;
        n4_next         = n3_reg[0];
        a4_next         = px3_reg;
        if (hit4[0])
        begin
            side4_next.c = min_x_reg;
        end
        else if (hit4[1])
        begin
            side4_next.c = max_x_reg;
            n4_next      = n3_reg[1];
        end
        else if (hit4[2])
        begin
            side4_next.swap = 1'b1;
            side4_next.c    = max_y_reg;
            n4_next         = n3_reg[2];
            a4_next         = py3_reg;
        end
        else if (hit4[3])
        begin
            side4_next.swap = 1'b1;
            side4_next.c    = min_y_reg;
            n4_next         = n3_reg[3];
            a4_next         = py3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv4 && v3_reg)
        begin
            n4_reg    <= n4_next;
            a4_reg    <= a4_next;
            side4_reg <= side4_next;
        end
    end

    // stages 5 onward: other coordinate = c * b / a
    logic                 dv_valid;
    logic signed [CW-1:0] dq;
    side_t                dside;
    logic                 out_adv;

    cptr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4_reg),
        .in_ready  (div_ready),
        .in_n      (n4_reg),
        .in_d      (a4_reg),
        .in_side   (side4_reg),
        .out_valid (dv_valid),
        .out_ready (out_adv),
        .out_q     (dq),
        .out_side  (dside)
    );

    // output register
    logic                 ov_reg, hit_reg;
    logic signed [CW-1:0] ox_reg, oy_reg;

    assign out_adv = !ov_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (out_adv)
            ov_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && dv_valid)
        begin
            hit_reg <= dside.hit;
            if (!dside.hit)
            begin
                ox_reg <= dside.px;
                oy_reg <= dside.py;
            end
            else if (dside.swap)
            begin
                ox_reg <= dq;
                oy_reg <= dside.c;
            end
            else
            begin
                ox_reg <= dside.c;
                oy_reg <= dq;
            end
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {oy_reg, ox_reg};
    assign m_tuser  = hit_reg;

    // ---------------- checks ----------------
    a_hit_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && side4_reg.hit |-> a4_reg != '0)
        else $error("edge hit selected with zero divisor");

    a_stage1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && !adv1 |=> v1_reg && $stable(px1_reg) && $stable(py1_reg))
        else $error("stalled point lost in stage 1");

    a_stage4_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && !div_ready |=> v4_reg && $stable(n4_reg))
        else $error("stalled word lost before divider");

endmodule
